// File: hw/rtl/cld_pkg.sv
// Shared types and constants for the LRU keyed cache directory.
// No dependencies; imported by every module of the block.
package cld_pkg;

    // Fixed field widths of the stream payloads
    localparam int IN_DATA_W  = 64;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 32;
    localparam int OUT_DATA_W = 72;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Recency update command from the top level to the age tracker
    typedef struct packed {
        logic en;     // touch a slot this cycle
        logic fresh;  // slot was empty, not yet on the recency order
    } cld_touch_t;

endpackage

// File: hw/rtl/cld_keys.sv
// Key store and parallel key compare for the LRU keyed cache directory.
// Depends on cld_pkg.
module cld_keys #(
    parameter int ENTRIES   = 16,
    parameter int KEY_WIDTH = 64,
    localparam int IDX_W    = $clog2(ENTRIES),
    localparam int CNT_W    = $clog2(ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic [KEY_WIDTH-1:0] lookup_key,
    input  logic [CNT_W-1:0]     fill_count,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_slot,
    output logic                 hit,
    output logic [IDX_W-1:0]     hit_slot
);
    import cld_pkg::*;

    logic [KEY_WIDTH-1:0] slot_keys_reg [ENTRIES];

    // Compare against filled slots only; lowest matching slot wins
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < fill_count) && (slot_keys_reg[i] == lookup_key))
            begin
                hit      = 1'b1;
                hit_slot = IDX_W'(i);
            end
        end
    end

    // Key write on a miss, into the filled or evicted slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_keys_reg[wr_slot] <= lookup_key;
        end
    end

endmodule

// File: hw/rtl/cld_age.sv
// Recency tracker: one age rank per slot, 0 is most recent.
// Depends on cld_pkg (cld_touch_t).
module cld_age #(
    parameter int ENTRIES = 16,
    localparam int IDX_W  = $clog2(ENTRIES),
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cld_pkg::cld_touch_t touch,
    input  logic [IDX_W-1:0]    touch_slot,
    input  logic [CNT_W-1:0]    fill_count,
    output logic [IDX_W-1:0]    victim,
    output logic                victim_found
);
    import cld_pkg::*;

    logic [IDX_W-1:0] age_reg  [ENTRIES];
    logic [IDX_W-1:0] age_next [ENTRIES];
    logic [IDX_W-1:0] ref_age;
    logic [ENTRIES-1:0] filled;

    // Filled mask and age of the touched slot
    always_comb
    begin
        ref_age = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            filled[i] = (CNT_W'(i) < fill_count);
            if (touch_slot == IDX_W'(i))
            begin
                ref_age = age_reg[i];
            end
        end
    end

    // Touched slot becomes youngest; filled slots younger than it (all if fresh) age by one
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            if (touch.en)
            begin
                if (touch_slot == IDX_W'(i))
                begin
                    age_next[i] = '0;
                end
                else if (filled[i] && (touch.fresh || (age_reg[i] < ref_age)))
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
        end
    end

    // Least recent slot: the one holding the oldest rank when full
    always_comb
    begin
        victim       = '0;
        victim_found = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (filled[i] && (age_reg[i] == IDX_W'(ENTRIES - 1)))
            begin
                victim       = IDX_W'(i);
                victim_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

endmodule

// File: hw/rtl/lru_keyed_cache_directory.sv
// Top level of the LRU keyed cache directory: input register, lookup and
// replacement decision, counters and result register. Depends on cld_pkg,
// cld_keys and cld_age.
//
//  channel | dir | payload (tdata, low bit first)
//  s_*     | in  | lookup_key[63:0]
//  m_*     | out | was_hit, slot_index[3:0], evicted, hit_total[31:0], miss_total[31:0]
//
// One item per cycle sustained while m_tready stays high; a result passes the input
// register and then the result register before its output transfer.
// The whole key compare, age update and counter update sit in one stage.
// Reset empties the directory at once and clears both counters.
// A stall on m_tready holds the result; the input register then holds one
// more item and s_tready drops until the result is taken.
module lru_keyed_cache_directory #(
    parameter int ENTRIES   = 16,
    parameter int KEY_WIDTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cld_pkg::IN_DATA_W-1:0]    s_tdata,   // lookup_key[63:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // was_hit[0], slot_index[4:1], evicted[5], hit_total[37:6], miss_total[69:38]
    output logic [cld_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import cld_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int PAD_W = OUT_DATA_W - (2 + SLOT_W + 2 * COUNT_W);

    logic                 in_valid_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     fill_count_reg, fill_count_next;
    logic [COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]   miss_cnt_reg, miss_cnt_next;

    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_evict_reg;
    logic [COUNT_W-1:0]   out_hit_cnt_reg;
    logic [COUNT_W-1:0]   out_miss_cnt_reg;

    logic                 advance;
    logic                 hit;
    logic [IDX_W-1:0]     hit_slot;
    logic [IDX_W-1:0]     victim;
    logic                 victim_found;
    logic                 full;
    logic                 evict;
    logic [IDX_W-1:0]     slot_sel;
    logic [IDX_W+SLOT_W-1:0] slot_wide;
    cld_touch_t           touch;

    // Handshake: stage moves when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    cld_keys #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_keys (
        .clk        (clk),
        .lookup_key (key_reg),
        .fill_count (fill_count_reg),
        .wr_en      (advance && !hit),
        .wr_slot    (slot_sel),
        .hit        (hit),
        .hit_slot   (hit_slot)
    );

    cld_age #(
        .ENTRIES (ENTRIES)
    ) u_age (
        .clk          (clk),
        .rst_n        (rst_n),
        .touch        (touch),
        .touch_slot   (slot_sel),
        .fill_count   (fill_count_reg),
        .victim       (victim),
        .victim_found (victim_found)
    );

    // Slot choice: hit slot, next empty slot, or least recent slot
    always_comb
    begin
        full  = (fill_count_reg == CNT_W'(ENTRIES));
        evict = !hit && full;
        if (hit)
        begin
            slot_sel = hit_slot;
        end
        else if (full)
        begin
            slot_sel = victim;
        end
        else
        begin
            slot_sel = fill_count_reg[IDX_W-1:0];
        end
        touch.en    = advance;
        touch.fresh = !hit && !full;
        slot_wide   = {{SLOT_W{1'b0}}, slot_sel};
    end

    // Fill count and saturating counters
    always_comb
    begin
        fill_count_next = fill_count_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        if (advance)
        begin
            if (hit)
            begin
                if (hit_cnt_reg != COUNT_MAX)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end
            else
            begin
                if (miss_cnt_reg != COUNT_MAX)
                begin
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                end
                if (!full)
                begin
                    fill_count_next = fill_count_reg + 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fill_count_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            fill_count_reg <= fill_count_next;
            hit_cnt_reg    <= hit_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            key_reg <= s_tdata[KEY_WIDTH-1:0];
        end
        if (advance)
        begin
            out_hit_reg      <= hit;
            out_slot_reg     <= slot_wide[SLOT_W-1:0];
            out_evict_reg    <= evict;
            out_hit_cnt_reg  <= hit_cnt_next;
            out_miss_cnt_reg <= miss_cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_miss_cnt_reg, out_hit_cnt_reg,
                       out_evict_reg, out_slot_reg, out_hit_reg};

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond entry count");

    a_victim_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> victim_found)
        else $error("full directory without a least recent slot");

    a_no_hit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg == '0) |-> !hit)
        else $error("hit reported on an empty directory");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !hit && (miss_cnt_reg != COUNT_MAX))
        |=> (miss_cnt_reg == $past(miss_cnt_reg) + 1'b1))
        else $error("miss counter did not advance on a miss");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && (out_hit_reg || (out_miss_cnt_reg != '0))))
        else $error("processed item left no result");

endmodule
